[hdl/rc_failsafe_mode_ppm_framer_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the failsafe PPM framer
// Shared concurrent assertion forms used by the framer modules.
// ----------------------------------------------------------------------------
`ifndef RC_FAILSAFE_MODE_PPM_FRAMER_TOP_ASSERT_SVH
`define RC_FAILSAFE_MODE_PPM_FRAMER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RCF_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RCF_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hdl/rcfppm_pkg.sv]
// ----------------------------------------------------------------------------
// rcfppm_pkg
// Shared types and constants of the failsafe mode selector and PPM framer.
// ----------------------------------------------------------------------------
package rcfppm_pkg;

  localparam int unsigned FramePeriodUs = 20000;
  localparam int unsigned PulseUs       = 300;
  localparam int unsigned RfChannels    = 16;
  localparam int unsigned AutoChannels  = 8;
  localparam int unsigned PpmSlots      = 8;

  localparam logic [10:0] Neutral11  = 11'd1500;
  localparam logic [15:0] Neutral16  = 16'd1500;
  localparam logic [10:0] ChMin      = 11'd1000;
  localparam logic [10:0] ChMax      = 11'd2000;
  localparam logic [10:0] LowOffset  = 11'd302;
  localparam logic [15:0] InvertBase = 16'd3000;
  localparam logic [8:0]  HighCount  = 9'(PulseUs - 2);
  localparam logic [14:0] SyncBase   = 15'(FramePeriodUs - PulseUs);

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RF    = 3'd1,
    OP_HB    = 3'd2,
    OP_AUTO  = 3'd3,
    OP_FRAME = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    MD_RF      = 3'd0,
    MD_AUTO    = 3'd1,
    MD_IDLE    = 3'd2,
    MD_AUTO_TO = 3'd3,
    MD_EMERG   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_RF_TO   = 3'd0,
    REG_HB_TO   = 3'd1,
    REG_CMD_TO  = 3'd2,
    REG_EMERG   = 3'd3,
    REG_AUTO    = 3'd4,
    REG_SEL_LO  = 3'd5,
    REG_SEL_HI  = 3'd6,
    REG_FIXED4  = 3'd7
  } reg_e;

  typedef struct packed {
    logic [15:0] rf_timeout;
    logic [15:0] hb_timeout;
    logic [15:0] cmd_timeout;
    logic [10:0] emerg_thr;
    logic [10:0] auto_thr;
    logic [10:0] sel_low;
    logic [10:0] sel_high;
    logic [10:0] fixed_ch4;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic       do_ctrl;   // apply a non-frame item
    logic       emit;      // emit slot at slot_idx
    logic [3:0] slot_idx;
    logic       update;    // expire flags, pick mode, rebuild outputs
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       link_ok;
  } stat_t;

  function automatic logic [10:0] clamp16(input logic [15:0] v);
    if (v < 16'(ChMin)) return ChMin;
    if (v > 16'(ChMax)) return ChMax;
    return v[10:0];
  endfunction

  function automatic logic [15:0] invert(input logic [15:0] v);
    return InvertBase - v;
  endfunction

endpackage

[hdl/rcfppm_ctrl.sv]
// ----------------------------------------------------------------------------
// rcfppm_ctrl
// Sequencer: accepts items, steps through the nine PPM slots of a frame.
// ----------------------------------------------------------------------------
`include "rc_failsafe_mode_ppm_framer_top_assert.svh"
module rcfppm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcfppm_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] slot_q, slot_d;
  logic       acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    cmd_o.slot_idx = slot_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (opcode_i == rcfppm_pkg::OP_FRAME) begin
            state_d = ST_EMIT;
            slot_d  = '0;
          end else begin
            cmd_o.do_ctrl = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          cmd_o.emit = 1'b1;
          if (slot_q == 4'(rcfppm_pkg::PpmSlots)) state_d = ST_UPD;
          else slot_d = slot_q + 4'd1;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  `RCF_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `RCF_ASSERT_IMP(a_slot_rng, clk_i, rst_ni, out_valid_o, slot_q <= 4'd8)
  `RCF_ASSERT_NXT(a_upd_idle, clk_i, rst_ni, cmd_o.update, in_ready_o)

endmodule

[hdl/rcfppm_dp.sv]
// ----------------------------------------------------------------------------
// rcfppm_dp
// Channel stores, age timers, slot arithmetic and mode selection.
// ----------------------------------------------------------------------------
`include "rc_failsafe_mode_ppm_framer_top_assert.svh"
module rcfppm_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcfppm_pkg::cmd_t   cmd_i,
  input  rcfppm_pkg::cfg_t   cfg_i,
  input  logic [2:0]         opcode_i,
  input  logic [3:0]         chan_index_i,
  input  logic [15:0]        chan_value_i,
  input  logic               last_word_i,
  output logic [14:0]        low_count_o,
  output rcfppm_pkg::stat_t  stat_o
);

  logic [10:0] rf_stg_q [16];
  logic [10:0] rf_ch_q  [16];
  logic [15:0] au_stg_q [8];
  logic [15:0] au_ch_q  [8];
  logic [15:0] out_q    [8];
  logic [15:0] rf_age_q, hb_age_q, cmd_age_q;
  logic        link_q, host_q, fresh_q;
  logic [14:0] sum_q;

  logic        link_n, host_n, fresh_n;
  logic [2:0]  mode_n;
  logic [10:0] ch;
  logic [15:0] sync_gap;

  // slot arithmetic
  always_comb begin
    ch = rcfppm_pkg::clamp16(out_q[cmd_i.slot_idx[2:0]]);
    sync_gap = 16'(rcfppm_pkg::SyncBase) - 16'(sum_q);
    if (cmd_i.slot_idx[3]) begin
      if ($signed(sync_gap) > 16'sd2) low_count_o = 15'(sync_gap - 16'd2);
      else low_count_o = '0;
    end else begin
      low_count_o = 15'(ch - rcfppm_pkg::LowOffset);
    end
  end

  // mode selection, on flags after expiry
  always_comb begin
    link_n  = link_q  && !(rf_age_q  > cfg_i.rf_timeout);
    host_n  = host_q  && !(hb_age_q  > cfg_i.hb_timeout);
    fresh_n = fresh_q && !(cmd_age_q > cfg_i.cmd_timeout);
    priority if (!link_n)                         mode_n = rcfppm_pkg::MD_EMERG;
    else if (rf_ch_q[4] < cfg_i.emerg_thr)        mode_n = rcfppm_pkg::MD_EMERG;
    else if (rf_ch_q[8] < cfg_i.sel_low)          mode_n = rcfppm_pkg::MD_IDLE;
    else if (rf_ch_q[8] <= cfg_i.sel_high) begin
      if (rf_ch_q[5] < cfg_i.auto_thr && host_n && fresh_n) mode_n = rcfppm_pkg::MD_AUTO;
      else if (rf_ch_q[5] < cfg_i.auto_thr && host_n) mode_n = rcfppm_pkg::MD_AUTO_TO;
      else mode_n = rcfppm_pkg::MD_IDLE;
    end else mode_n = rcfppm_pkg::MD_RF;
  end

  // the mode shown on slots is the one picked at the end of this frame
  assign stat_o.mode    = mode_n;
  assign stat_o.link_ok = link_n;

  function automatic logic [15:0] age_up(input logic [15:0] a);
    return (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        rf_stg_q[i] <= rcfppm_pkg::Neutral11;
        rf_ch_q[i]  <= rcfppm_pkg::Neutral11;
      end
      for (int i = 0; i < 8; i++) begin
        au_stg_q[i] <= rcfppm_pkg::Neutral16;
        au_ch_q[i]  <= rcfppm_pkg::Neutral16;
        out_q[i]    <= rcfppm_pkg::Neutral16;
      end
      rf_age_q  <= '0;
      hb_age_q  <= '0;
      cmd_age_q <= '0;
      link_q    <= 1'b0;
      host_q    <= 1'b0;
      fresh_q   <= 1'b0;
      sum_q     <= '0;
    end else begin
      if (cmd_i.do_ctrl) begin
        unique case (opcode_i)
          rcfppm_pkg::OP_TICK: begin
            rf_age_q  <= age_up(rf_age_q);
            hb_age_q  <= age_up(hb_age_q);
            cmd_age_q <= age_up(cmd_age_q);
          end
          rcfppm_pkg::OP_RF: begin
            rf_stg_q[chan_index_i] <= rcfppm_pkg::clamp16(chan_value_i);
            if (last_word_i) begin
              // commit staging with this beat's word folded in
              for (int i = 0; i < 16; i++)
                rf_ch_q[i] <= (4'(i) == chan_index_i) ?
                              rcfppm_pkg::clamp16(chan_value_i) : rf_stg_q[i];
              link_q   <= 1'b1;
              rf_age_q <= '0;
            end
          end
          rcfppm_pkg::OP_HB: begin
            host_q   <= 1'b1;
            hb_age_q <= '0;
          end
          rcfppm_pkg::OP_AUTO: begin
            if (!chan_index_i[3]) au_stg_q[chan_index_i[2:0]] <= chan_value_i;
            if (last_word_i) begin
              for (int i = 0; i < 8; i++)
                au_ch_q[i] <= (!chan_index_i[3] && 3'(i) == chan_index_i[2:0]) ?
                              chan_value_i : au_stg_q[i];
              fresh_q   <= 1'b1;
              cmd_age_q <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        if (cmd_i.slot_idx == '0) sum_q <= 15'(ch);
        else if (!cmd_i.slot_idx[3]) sum_q <= sum_q + 15'(ch);
      end
      if (cmd_i.update) begin
        link_q  <= link_n;
        host_q  <= host_n;
        fresh_q <= fresh_n;
        unique case (mode_n)
          rcfppm_pkg::MD_RF: begin
            out_q[0] <= 16'(rf_ch_q[2]);
            out_q[1] <= rcfppm_pkg::invert(16'(rf_ch_q[0]));
            out_q[2] <= 16'(rf_ch_q[4]);
            out_q[3] <= 16'(cfg_i.fixed_ch4);
            out_q[4] <= 16'(rf_ch_q[10]);
            out_q[5] <= 16'(rf_ch_q[11]);
            out_q[6] <= rcfppm_pkg::invert(16'(rf_ch_q[6]));
            out_q[7] <= rcfppm_pkg::invert(16'(rf_ch_q[7]));
          end
          rcfppm_pkg::MD_AUTO: begin
            out_q[0] <= au_ch_q[0];
            out_q[1] <= au_ch_q[1];
            out_q[2] <= au_ch_q[2];
            out_q[3] <= 16'(cfg_i.fixed_ch4);
            out_q[4] <= au_ch_q[4];
            out_q[5] <= au_ch_q[5];
            out_q[6] <= rcfppm_pkg::invert(au_ch_q[6]);
            out_q[7] <= rcfppm_pkg::invert(au_ch_q[7]);
          end
          default: for (int i = 0; i < 8; i++) out_q[i] <= rcfppm_pkg::Neutral16;
        endcase
      end
    end
  end

  `RCF_ASSERT_IMP(a_link_mode, clk_i, rst_ni, !link_n,
                  mode_n == rcfppm_pkg::MD_EMERG)
  `RCF_ASSERT_NXT(a_rf_commit, clk_i, rst_ni,
                  cmd_i.do_ctrl && opcode_i == rcfppm_pkg::OP_RF && last_word_i,
                  link_q && rf_age_q == '0)
  `RCF_ASSERT_IMP(a_sum_rng, clk_i, rst_ni, 1'b1, sum_q <= 15'd16000)

endmodule

[hdl/rc_failsafe_mode_ppm_framer_top.sv]
// ----------------------------------------------------------------------------
// rc_failsafe_mode_ppm_framer_top
// Failsafe mode selector and PPM frame slot generator with APB registers.
// ----------------------------------------------------------------------------
// One item is taken at a time. Tick, RF word, heartbeat and autonomous word
// items are applied when accepted. A frame event is accepted and then sent as
// nine slot beats (channels 0..7, then the sync slot with frame_end set), each
// held until the output side takes it; an update step then expires flags,
// latches the mode and rebuilds the output channels. Each slot beat carries
// the mode and link flag that this frame's update will commit.
// Registers sit at byte addresses 4*i, are written in the APB access cycle and
// read back at any time; write them only while no frame is in flight.
module rc_failsafe_mode_ppm_framer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // chan_index[3:0], chan_value[19:4], 0
  input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
  input  logic        s_axis_tlast,   // last_word
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // slot[3:0], high_count[12:4], low_count[27:13],
                                      // new_mode[30:28], link_ok[31]
  output logic        m_axis_tlast    // frame_end
);

  rcfppm_pkg::cfg_t  cfg_q;
  rcfppm_pkg::cmd_t  cmd;
  rcfppm_pkg::stat_t stat;
  logic [14:0]       low_count;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // register file: mask values to width, ignore unknown offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rf_timeout  <= 16'd500;
      cfg_q.hb_timeout  <= 16'd300;
      cfg_q.cmd_timeout <= 16'd500;
      cfg_q.emerg_thr   <= 11'd1700;
      cfg_q.auto_thr    <= 11'd1700;
      cfg_q.sel_low     <= 11'd1250;
      cfg_q.sel_high    <= 11'd1750;
      cfg_q.fixed_ch4   <= 11'd1939;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        rcfppm_pkg::REG_RF_TO:  cfg_q.rf_timeout  <= pwdata[15:0];
        rcfppm_pkg::REG_HB_TO:  cfg_q.hb_timeout  <= pwdata[15:0];
        rcfppm_pkg::REG_CMD_TO: cfg_q.cmd_timeout <= pwdata[15:0];
        rcfppm_pkg::REG_EMERG:  cfg_q.emerg_thr   <= pwdata[10:0];
        rcfppm_pkg::REG_AUTO:   cfg_q.auto_thr    <= pwdata[10:0];
        rcfppm_pkg::REG_SEL_LO: cfg_q.sel_low     <= pwdata[10:0];
        rcfppm_pkg::REG_SEL_HI: cfg_q.sel_high    <= pwdata[10:0];
        rcfppm_pkg::REG_FIXED4: cfg_q.fixed_ch4   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (paddr[4:2])
      rcfppm_pkg::REG_RF_TO:  prdata = 32'(cfg_q.rf_timeout);
      rcfppm_pkg::REG_HB_TO:  prdata = 32'(cfg_q.hb_timeout);
      rcfppm_pkg::REG_CMD_TO: prdata = 32'(cfg_q.cmd_timeout);
      rcfppm_pkg::REG_EMERG:  prdata = 32'(cfg_q.emerg_thr);
      rcfppm_pkg::REG_AUTO:   prdata = 32'(cfg_q.auto_thr);
      rcfppm_pkg::REG_SEL_LO: prdata = 32'(cfg_q.sel_low);
      rcfppm_pkg::REG_SEL_HI: prdata = 32'(cfg_q.sel_high);
      rcfppm_pkg::REG_FIXED4: prdata = 32'(cfg_q.fixed_ch4);
      default:                prdata = '0;
    endcase
  end

  // hold the accepted item's fields: the datapath samples them in the accept cycle
  rcfppm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  rcfppm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg_q),
    .opcode_i     (s_axis_tuser),
    .chan_index_i (s_axis_tdata[3:0]),
    .chan_value_i (s_axis_tdata[19:4]),
    .last_word_i  (s_axis_tlast),
    .low_count_o  (low_count),
    .stat_o       (stat)
  );

  assign m_axis_tdata = {stat.link_ok, stat.mode, low_count, rcfppm_pkg::HighCount,
                         cmd.slot_idx};
  assign m_axis_tlast = cmd.slot_idx[3];

endmodule
